// ----- design/aivdm_pkg.sv -----
package aivdm_pkg;

    localparam int TERM_MAX_DEF = 64;

    // special characters
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // sentence kind "AIVDM"
    localparam int KIND_LEN = 5;

    // term positions
    localparam logic [7:0] TI_KIND    = 8'd0;
    localparam logic [7:0] TI_TOTAL   = 8'd1;
    localparam logic [7:0] TI_NUMBER  = 8'd2;
    localparam logic [7:0] TI_ID      = 8'd3;
    localparam logic [7:0] TI_PAYLOAD = 8'd5;
    localparam logic [7:0] TI_SAT     = 8'd255;

    typedef struct packed {
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frag_total;
        logic [7:0] frag_number;
        logic [7:0] message_id;
        logic [7:0] payload_char;
        logic       char_valid;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] total;
        logic [7:0] number;
        logic [7:0] id;
    } held_t;

    typedef struct packed {
        logic       store;
        logic       commit;
        logic       emit;
        logic [7:0] wr_char;
    } parse_cmd_t;

    typedef enum logic {
        EMIT_IDLE,
        EMIT_RUN
    } emit_state_t;

    function automatic logic [7:0] kind_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h41;
            3'd1:    c = 8'h49;
            3'd2:    c = 8'h56;
            3'd3:    c = 8'h44;
            3'd4:    c = 8'h4D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = 4'(c - 8'h30);
        end else if (c inside {[8'h41:8'h46]}) begin
            v = 4'(c - 8'h37);
        end else if (c inside {[8'h61:8'h66]}) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

// ----- design/aivdm_stream_if.sv -----
interface aivdm_stream_if #(parameter type item_t = logic);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- design/aivdm_sentence_parser.sv -----
// aivdm sentence parser
// chars: one received character per transaction (sink). every character is
//   taken in a single cycle; ready is high whenever no payload run is active
// results: one payload character per transaction (source), with the fragment
//   total, fragment number and message id of the sentence and a last marker.
//   a passing sentence with an empty stored payload gives one transaction with
//   char_valid low
// order: the run starts when the checksum term's terminator is taken; each
//   result passes the memory read register and then the result register, and
//   results are offered one per cycle while the receiver takes them
// payload run: a run of n results (1 to 63) keeps chars stalled until its
//   last result is loaded, since the payload memory has a single read port
//   feeding the result register
// reset: clears all parsing and handshake state; the memory contents stay
//   undefined and no unwritten entry ever reaches a result
// stall: the result register holds its transaction and the memory reads pause
//   until results.ready returns; chars resume once the run state returns to
//   idle after the last result is loaded into the result register
module aivdm_sentence_parser #(
    parameter int TERM_MAX = aivdm_pkg::TERM_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    aivdm_stream_if.sink   chars,
    aivdm_stream_if.source results
);
    import aivdm_pkg::*;

    // term memory address width, also wide enough for a term length
    localparam int ADDR_W = $clog2(TERM_MAX);

    parse_cmd_t        cmd;
    held_t             held;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] term_len;
    logic              busy;
    logic              fire;

    // characters flow only while no payload run is reading the memory
    assign chars.ready = !busy;
    assign fire        = chars.valid && chars.ready;

    // term parsing: checksum, decimal fields, kind check and term writes
    aivdm_parse #(
        .TERM_MAX (TERM_MAX),
        .ADDR_W   (ADDR_W)
    ) u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .ch       (chars.data.ch),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .term_len (term_len),
        .held     (held)
    );

    // banked term / payload memory and the result sequencer
    aivdm_emit #(
        .TERM_MAX (TERM_MAX),
        .ADDR_W   (ADDR_W)
    ) u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .term_len (term_len),
        .held     (held),
        .busy     (busy),
        .results  (results)
    );

endmodule

// ----- design/aivdm_parse.sv -----
module aivdm_parse #(
    parameter int TERM_MAX = aivdm_pkg::TERM_MAX_DEF,
    parameter int ADDR_W   = $clog2(TERM_MAX)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          ch,
    output aivdm_pkg::parse_cmd_t cmd,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [ADDR_W-1:0]   term_len,
    output aivdm_pkg::held_t    held
);
    import aivdm_pkg::*;

    localparam logic [ADDR_W-1:0] TERM_CAP = ADDR_W'(TERM_MAX - 1);
    localparam logic [ADDR_W-1:0] KIND_END = ADDR_W'(KIND_LEN);

    logic              ok_reg, ok_next;
    logic              fin_reg, fin_next;
    logic              inck_reg, inck_next;
    logic [7:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [7:0]        xor_reg, xor_next;
    logic              name_ok_reg, name_ok_next;
    logic [7:0]        dec_reg, dec_next;
    logic              dec_stop_reg, dec_stop_next;
    logic [3:0]        hex_hi_reg, hex_hi_next;
    logic [3:0]        hex_lo_reg, hex_lo_next;
    held_t             held_reg, held_next;
    logic              is_term;

    assign is_term  = (ch == CH_COMMA) || (ch == CH_CR) || (ch == CH_LF) || (ch == CH_STAR);
    assign wr_addr  = len_reg;
    assign term_len = len_reg;
    assign held     = held_reg;

    always_comb
    begin
        ok_next       = ok_reg;
        fin_next      = fin_reg;
        inck_next     = inck_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        xor_next      = xor_reg;
        name_ok_next  = name_ok_reg;
        dec_next      = dec_reg;
        dec_stop_next = dec_stop_reg;
        hex_hi_next   = hex_hi_reg;
        hex_lo_next   = hex_lo_reg;
        held_next     = held_reg;
        cmd           = '0;
        cmd.wr_char   = ch;
        if (fire)
        begin
            if (ch == CH_BANG)
            begin
                ok_next       = 1'b0;
                fin_next      = 1'b0;
                inck_next     = 1'b0;
                idx_next      = '0;
                len_next      = '0;
                xor_next      = '0;
                name_ok_next  = 1'b1;
                dec_next      = '0;
                dec_stop_next = 1'b0;
                hex_hi_next   = '0;
                hex_lo_next   = '0;
            end
            else if (is_term)
            begin
                // the comma enters the checksum before the term is closed
                if (ch == CH_COMMA)
                begin
                    xor_next = xor_reg ^ CH_COMMA;
                end
                if (!fin_reg)
                begin
                    if (inck_reg)
                    begin
                        fin_next = 1'b1;
                        cmd.emit = ({hex_hi_reg, hex_lo_reg} == xor_next) && ok_reg;
                    end
                    else if (idx_reg == TI_KIND)
                    begin
                        if ((len_reg == KIND_END) && name_ok_reg)
                        begin
                            ok_next = 1'b1;
                        end
                    end
                    else if (ok_reg)
                    begin
                        case (idx_reg)
                            TI_TOTAL:   held_next.total = dec_reg;
                            TI_NUMBER:  held_next.number = dec_reg;
                            TI_ID:
                            begin
                                held_next.id = (len_reg != '0) ? dec_reg : 8'd0;
                                if ((len_reg == '0) &&
                                    ((held_reg.number != 8'd1) || (held_reg.total != 8'd1)))
                                begin
                                    ok_next = 1'b0;
                                end
                            end
                            TI_PAYLOAD:
                            begin
                                if (len_reg == '0)
                                begin
                                    ok_next = 1'b0;
                                end
                                else
                                begin
                                    cmd.commit = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                    idx_next      = (idx_reg == TI_SAT) ? idx_reg : idx_reg + 8'd1;
                    len_next      = '0;
                    inck_next     = (ch == CH_STAR);
                    name_ok_next  = 1'b1;
                    dec_next      = '0;
                    dec_stop_next = 1'b0;
                    hex_hi_next   = '0;
                    hex_lo_next   = '0;
                end
            end
            else
            begin
                if (len_reg < TERM_CAP)
                begin
                    cmd.store = 1'b1;
                    len_next  = len_reg + 1'b1;
                    if ((len_reg < KIND_END) && (ch != kind_char(len_reg[2:0])))
                    begin
                        name_ok_next = 1'b0;
                    end
                    if (!dec_stop_reg)
                    begin
                        if (is_digit(ch))
                        begin
                            dec_next = 8'(dec_reg * 8'd10) + 8'(ch - CH_ZERO);
                        end
                        else
                        begin
                            dec_stop_next = 1'b1;
                        end
                    end
                    if (len_reg == '0)
                    begin
                        hex_hi_next = hex_value(ch);
                    end
                    if (len_reg == ADDR_W'(1))
                    begin
                        hex_lo_next = hex_value(ch);
                    end
                end
                if (!inck_reg)
                begin
                    xor_next = xor_reg ^ ch;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ok_reg       <= 1'b0;
            fin_reg      <= 1'b0;
            inck_reg     <= 1'b0;
            idx_reg      <= '0;
            len_reg      <= '0;
            xor_reg      <= '0;
            name_ok_reg  <= 1'b1;
            dec_reg      <= '0;
            dec_stop_reg <= 1'b0;
            hex_hi_reg   <= '0;
            hex_lo_reg   <= '0;
            held_reg     <= '0;
        end
        else
        begin
            ok_reg       <= ok_next;
            fin_reg      <= fin_next;
            inck_reg     <= inck_next;
            idx_reg      <= idx_next;
            len_reg      <= len_next;
            xor_reg      <= xor_next;
            name_ok_reg  <= name_ok_next;
            dec_reg      <= dec_next;
            dec_stop_reg <= dec_stop_next;
            hex_hi_reg   <= hex_hi_next;
            hex_lo_reg   <= hex_lo_next;
            held_reg     <= held_next;
        end
    end

endmodule

// ----- design/aivdm_emit.sv -----
module aivdm_emit #(
    parameter int TERM_MAX = aivdm_pkg::TERM_MAX_DEF,
    parameter int ADDR_W   = $clog2(TERM_MAX)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  aivdm_pkg::parse_cmd_t cmd,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  logic [ADDR_W-1:0]     term_len,
    input  aivdm_pkg::held_t      held,
    output logic                  busy,
    aivdm_stream_if.source        results
);
    import aivdm_pkg::*;

    localparam int DEPTH = 2 ** (ADDR_W + 1);

    // two banks: one holds the payload, the other collects the current term
    logic [7:0]        mem [DEPTH];

    emit_state_t       state_reg, state_next;
    logic              bank_reg, bank_next;
    logic [ADDR_W-1:0] plen_reg, plen_next;
    logic [ADDR_W-1:0] rd_idx_reg, rd_idx_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        rd_data_reg;
    out_item_t         out_data_reg;
    logic [ADDR_W-1:0] count;
    logic              run;
    logic              can_load;
    logic              rd_en;

    assign count = (plen_reg == '0) ? ADDR_W'(1) : plen_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            EMIT_IDLE:
            begin
                if (cmd.emit)
                begin
                    state_next = EMIT_RUN;
                end
            end
            EMIT_RUN:
            begin
                if ((rd_idx_reg == count) && !rd_vld_reg)
                begin
                    state_next = EMIT_IDLE;
                end
            end
            default: state_next = EMIT_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            EMIT_RUN:
            begin
                busy = 1'b1;
                run  = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
                run  = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        can_load       = rd_vld_reg && (!out_valid_reg || results.ready);
        rd_en          = run && (rd_idx_reg != count) && (!rd_vld_reg || can_load);
        rd_idx_next    = rd_idx_reg;
        rd_vld_next    = rd_vld_reg;
        bank_next      = bank_reg;
        plen_next      = plen_reg;
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            rd_idx_next = '0;
            rd_vld_next = 1'b0;
        end
        else if (rd_en)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            rd_vld_next = 1'b1;
        end
        else if (can_load)
        begin
            rd_vld_next = 1'b0;
        end
        if (cmd.commit)
        begin
            bank_next = !bank_reg;
            plen_next = term_len;
        end
        if (can_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EMIT_IDLE;
            bank_reg      <= 1'b0;
            plen_reg      <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            plen_reg      <= plen_next;
            rd_idx_reg    <= rd_idx_next;
            rd_vld_reg    <= rd_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[{!bank_reg, wr_addr}] <= cmd.wr_char;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[{bank_reg, rd_idx_reg}];
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load)
        begin
            out_data_reg.frag_total   <= held.total;
            out_data_reg.frag_number  <= held.number;
            out_data_reg.message_id   <= held.id;
            out_data_reg.payload_char <= (plen_reg != '0) ? rd_data_reg : 8'd0;
            out_data_reg.char_valid   <= (plen_reg != '0);
            out_data_reg.last         <= (rd_idx_reg == count);
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

endmodule

// ----- tb/aivdm_sentence_checker.sv -----
`timescale 1ns / 100ps

module aivdm_sentence_checker
    import aivdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      chars_valid,
    input  logic      chars_ready,
    input  in_item_t  chars_data,
    input  logic      results_valid,
    input  logic      results_ready,
    input  out_item_t results_data,
    output int        fail_count,
    output int        pending,
    output int        results_seen,
    output int        runs_seen
);

    localparam int TERM_CAP = (TERM_MAX_DEF - 1 > 63) ? 63 : TERM_MAX_DEF - 1;
    localparam logic [39:0] KIND_TEXT = "AIVDM";

    // parser state
    logic       sent_ok;
    logic       finished;
    logic       in_cksum;
    logic [7:0] term_idx;
    logic [5:0] term_len;
    logic [7:0] run_xor;
    logic [7:0] term_buf [64];
    logic [7:0] held_total;
    logic [7:0] held_number;
    logic [7:0] held_id;
    logic [7:0] pay_buf [64];
    logic [5:0] pay_len;

    out_item_t payload_due [$];

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9") v = 4'(c - "0");
        else if (c >= "A" && c <= "F") v = 4'(c - "A" + 10);
        else if (c >= "a" && c <= "f") v = 4'(c - "a" + 10);
        return v;
    endfunction

    function automatic logic [7:0] stored_char(input int i);
        return (i < int'(term_len)) ? term_buf[i] : 8'd0;
    endfunction

    // leading digits, modulo 256
    function automatic logic [7:0] term_number();
        logic [7:0] acc;
        logic       stop;
        acc = 8'd0;
        stop = 1'b0;
        for (int i = 0; i < int'(term_len); i++) begin
            if (term_buf[i] < "0" || term_buf[i] > "9") stop = 1'b1;
            if (!stop) acc = 8'(acc * 10 + (term_buf[i] - "0"));
        end
        return acc;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    task automatic take_char(input logic [7:0] c);
        logic       pass;
        logic [7:0] sum;
        int         n;
        out_item_t  r;
        pass = 1'b0;
        if (c == CH_BANG) begin
            sent_ok  = 1'b0;
            finished = 1'b0;
            in_cksum = 1'b0;
            term_idx = 8'd0;
            term_len = 6'd0;
            run_xor  = 8'd0;
        end else if (c == CH_COMMA || c == CH_CR || c == CH_LF || c == CH_STAR) begin
            if (c == CH_COMMA) run_xor ^= CH_COMMA;
            if (!finished) begin
                if (in_cksum) begin
                    finished = 1'b1;
                    sum = {digit_value(stored_char(0)), digit_value(stored_char(1))};
                    pass = (sum == run_xor) && sent_ok;
                end else if (term_idx == TI_KIND) begin
                    if (term_len == 6'd5 && {term_buf[0], term_buf[1], term_buf[2],
                                             term_buf[3], term_buf[4]} == KIND_TEXT)
                        sent_ok = 1'b1;
                end else if (sent_ok) begin
                    case (term_idx)
                        TI_TOTAL:  held_total = term_number();
                        TI_NUMBER: held_number = term_number();
                        TI_ID:
                        begin
                            held_id = 8'd0;
                            if (term_len != 0) held_id = term_number();
                            else if (held_number != 8'd1 || held_total != 8'd1) sent_ok = 1'b0;
                        end
                        TI_PAYLOAD:
                        begin
                            if (term_len == 0) begin
                                sent_ok = 1'b0;
                            end else begin
                                for (int i = 0; i < int'(term_len); i++) pay_buf[i] = term_buf[i];
                                pay_len = term_len;
                            end
                        end
                        default: ;
                    endcase
                end
                if (term_idx != TI_SAT) term_idx++;
                term_len = 6'd0;
                in_cksum = (c == CH_STAR);
                if (pass) begin
                    n = (pay_len != 0) ? int'(pay_len) : 1;
                    for (int k = 0; k < n; k++) begin
                        r.frag_total   = held_total;
                        r.frag_number  = held_number;
                        r.message_id   = held_id;
                        r.payload_char = (pay_len != 0) ? pay_buf[k] : 8'd0;
                        r.char_valid   = (pay_len != 0);
                        r.last         = (k == n - 1);
                        payload_due.push_back(r);
                    end
                end
            end
        end else begin
            if (term_len < TERM_CAP) begin
                term_buf[term_len] = c;
                term_len++;
            end
            if (!in_cksum) run_xor ^= c;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n) begin
            sent_ok     = 1'b0;
            finished    = 1'b0;
            in_cksum    = 1'b0;
            term_idx    = 8'd0;
            term_len    = 6'd0;
            run_xor     = 8'd0;
            held_total  = 8'd0;
            held_number = 8'd0;
            held_id     = 8'd0;
            pay_len     = 6'd0;
            payload_due.delete();
            pending     = 0;
        end else begin
            if (results_valid && results_ready) begin
                results_seen++;
                if (results_data.last === 1'b1) runs_seen++;
                if (payload_due.size() == 0) begin
                    note_failure($sformatf("result %h with nothing expected", results_data));
                end else begin
                    want = payload_due.pop_front();
                    // all fields at once, x counts as wrong
                    if (results_data !== want)
                        note_failure($sformatf(
                            "exp total %0d number %0d id %0d char %h valid %b last %b, got total %0d number %0d id %0d char %h valid %b last %b",
                            want.frag_total, want.frag_number, want.message_id,
                            want.payload_char, want.char_valid, want.last,
                            results_data.frag_total, results_data.frag_number,
                            results_data.message_id, results_data.payload_char,
                            results_data.char_valid, results_data.last));
                end
            end
            if (chars_valid && chars_ready) take_char(chars_data.ch);
            pending = payload_due.size();
        end
    end

endmodule

// ----- tb/aivdm_sentence_parser_test.sv -----
`timescale 1ns / 100ps

module aivdm_sentence_parser_test;
    import aivdm_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    // 12 ns clock
    always #6 clk = ~clk;

    aivdm_stream_if #(.item_t(in_item_t))  chars_if ();
    aivdm_stream_if #(.item_t(out_item_t)) results_if ();

    aivdm_sentence_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .results (results_if)
    );

    int fail_count;
    int pending;
    int results_seen;
    int runs_seen;

    // prediction and comparison live in the checker, this module only drives
    aivdm_sentence_checker parse_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .chars_valid   (chars_if.valid),
        .chars_ready   (chars_if.ready),
        .chars_data    (chars_if.data),
        .results_valid (results_if.valid),
        .results_ready (results_if.ready),
        .results_data  (results_if.data),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .runs_seen     (runs_seen)
    );

    // idling switches, cleared for the quiet stretch
    bit src_idle = 1'b1;
    bit snk_idle = 1'b1;
    // long receiver hold-off: stimulus bumps the request count, receiver serves it
    int hold_requests = 0;
    int chars_sent = 0;

    // sentence under construction: body is everything between '!' and '*'
    logic [7:0] body_q [$];
    logic [7:0] line_q [$];

    // ------------------------------------------------------------------
    // receiver: random ready at the falling edge, long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left = 0;
        hold_served = 0;
        results_if.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_requests != hold_served) begin
                hold_served = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                results_if.ready <= 1'b0;
            end else begin
                results_if.ready <= !(snk_idle && $urandom_range(99) < 28);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog, far beyond the slowest legal run
    // ------------------------------------------------------------------
    initial
    begin
        #5000000;
        $display("FAIL aivdm_sentence_parser");
        $finish;
    end

    // ------------------------------------------------------------------
    // sender helpers, all called at a falling edge
    // ------------------------------------------------------------------

    // one transaction; valid stays high on return so the next call can reuse it
    task automatic send_char(input logic [7:0] c);
        while (src_idle && $urandom_range(99) < 28) begin
            chars_if.valid <= 1'b0;
            @(negedge clk);
        end
        chars_if.valid <= 1'b1;
        chars_if.data  <= in_item_t'(c);
        @(posedge clk);
        while (!chars_if.ready) @(posedge clk);
        @(negedge clk);
        chars_sent++;
    endtask

    task automatic send_raw(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
    endtask

    task automatic body_str(input string s);
        for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
    endtask

    // xor that the sentence body produces: cr and lf end terms but are not summed
    function automatic logic [7:0] body_xor();
        logic [7:0] x;
        x = 8'd0;
        foreach (body_q[i])
            if (body_q[i] != CH_CR && body_q[i] != CH_LF) x ^= body_q[i];
        return x;
    endfunction

    function automatic bit is_special(input logic [7:0] c);
        return c == CH_BANG || c == CH_STAR || c == CH_COMMA || c == CH_CR || c == CH_LF;
    endfunction

    // append ordinary chars (zeros if needed, then one more) so the body sums to target
    task automatic tune_xor(input logic [7:0] target);
        logic [7:0] c;
        c = body_xor() ^ target;
        while (is_special(c)) begin
            body_q.push_back("0");
            c = body_xor() ^ target;
        end
        body_q.push_back(c);
    endtask

    function automatic string cks_text(input logic [7:0] v, input bit lower);
        return lower ? $sformatf("%02x", v) : $sformatf("%02X", v);
    endfunction

    // mostly six-bit ais alphabet, now and then any ordinary byte
    function automatic logic [7:0] payload_char();
        logic [7:0] c;
        int v;
        if ($urandom_range(99) < 92) begin
            v = $urandom_range(63);
            c = (v < 40) ? 8'(v + 48) : 8'(v + 56);
        end else begin
            c = 8'($urandom_range(255));
            while (is_special(c)) c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task automatic add_payload(input int n);
        for (int i = 0; i < n; i++) body_q.push_back(payload_char());
    endtask

    // '!' body '*' checksum ending, cut short after keep chars when keep >= 0
    task automatic send_sentence(input string cks, input string ending, input int keep);
        line_q.delete();
        line_q.push_back(CH_BANG);
        foreach (body_q[i]) line_q.push_back(body_q[i]);
        line_q.push_back(CH_STAR);
        for (int i = 0; i < cks.len(); i++) line_q.push_back(cks[i]);
        for (int i = 0; i < ending.len(); i++) line_q.push_back(ending[i]);
        body_q.delete();
        for (int i = 0; i < line_q.size() && (keep < 0 || i < keep); i++)
            send_char(line_q[i]);
    endtask

    task automatic send_checked(input bit lower);
        send_sentence(cks_text(body_xor(), lower), "\r\n", -1);
    endtask

    // decimal term text: mostly small, some wrap mod 256, junk suffix, sign, space
    function automatic string dec_text();
        int r;
        r = $urandom_range(99);
        if (r < 40) return "1";
        if (r < 75) return $sformatf("%0d", $urandom_range(9));
        if (r < 88) return $sformatf("%0d", $urandom_range(999, 10));
        if (r < 94) return $sformatf("%0dx", $urandom_range(99));
        if (r < 97) return $sformatf("-%0d", $urandom_range(9));
        return $sformatf(" %0d", $urandom_range(9));
    endfunction

    // well formed layout with random content; cut sends only a prefix
    task automatic random_sentence(input bit cut);
        int    r;
        int    n;
        logic [7:0] x;
        string cks;
        string ending;
        r = $urandom_range(99);
        if (r < 94) body_str("AIVDM");
        else if (r < 96) body_str("AIVDO");
        else if (r < 98) body_str("AIVDMM");
        else body_str("GPVDM");
        body_str({",", dec_text(), ",", dec_text()});
        // a few sentences stop early and keep earlier held values
        if ($urandom_range(99) >= 5) begin
            body_str(",");
            if ($urandom_range(99) >= 30) body_str(dec_text());
            r = $urandom_range(2);
            if (r == 0) body_str(",A,");
            else if (r == 1) body_str(",B,");
            else body_str(",,");
            r = $urandom_range(99);
            if (r < 3) n = 0;
            else if (r < 75) n = $urandom_range(12, 1);
            else if (r < 93) n = $urandom_range(40, 13);
            else n = $urandom_range(70, 41);
            add_payload(n);
            body_str($sformatf(",%0d", $urandom_range(5)));
        end
        x = body_xor();
        r = $urandom_range(99);
        if (r < 45) cks = cks_text(x, 1'b0);
        else if (r < 80) cks = cks_text(x, 1'b1);
        else if (r < 90) cks = cks_text(x ^ 8'($urandom_range(255, 1)), 1'b0);
        else if (r < 95) cks = {cks_text(x, 1'b0), "ZZ"};
        else cks = $sformatf("%X", x[7:4]);
        r = $urandom_range(99);
        if (r < 80) ending = "\r\n";
        else if (r < 90) ending = "\r";
        else ending = "\n";
        n = body_q.size() + cks.len() + ending.len() + 2;
        send_sentence(cks, ending, cut ? $urandom_range(n - 1, 1) : -1);
    endtask

    // ------------------------------------------------------------------
    // main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        rst_n = 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.data  <= '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // nothing stored yet: a passing sentence gives one empty result
        body_str("AIVDM,3,2,7");
        send_checked(1'b0);

        // byte extremes in the payload, empty id allowed with 1,1, lower hex
        body_str("AIVDM,1,1,,A,");
        body_q.push_back(8'h00);
        body_q.push_back(8'hFF);
        body_str("0w");
        send_checked(1'b1);
        // after the checksum term, terminators do nothing until the next '!'
        send_raw("X,*,\n");

        // sender pause until every expected result is out
        chars_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        // receiver holds off during an over-long payload: totals wrap mod 256,
        // digits stop at junk, the tail past the longest stored term is dropped
        // but still summed, and chars stalls behind the payload run
        hold_requests++;
        body_str("AIVDM,300,255,12a,B,");
        add_payload(64);
        send_checked(1'b0);

        // empty payload term invalidates and keeps the stored payload
        body_str("AIVDM,1,1,9,A,");
        send_checked(1'b1);

        // no idling on either side through the checksum forms and the restart
        src_idle = 1'b0;
        snk_idle = 1'b0;
        // checksum forms: single digit, no digit, non-hex digit with extra chars
        body_str("AIVDM,1,1,6,A,k");
        tune_xor(8'h50);
        send_sentence("5", "\r\n", -1);
        body_str("AIVDM,1,1,6,A,m");
        tune_xor(8'h00);
        send_sentence("", "\r\n", -1);
        body_str("AIVDM,1,1,6,A,n");
        tune_xor(8'h07);
        send_sentence("G7Z", "\r\n", -1);
        // '!' in the middle restarts parsing
        send_raw("!AIVDM,1");
        body_str("AIVDM,1,1,3,A,yy");
        send_checked(1'b0);
        src_idle = 1'b1;
        snk_idle = 1'b1;

        // cr and lf as term separators, outside the sum
        body_str("AIVDM\n1\r1,3,A,lf");
        send_checked(1'b1);

        // random part: mostly well formed sentences, some cut short, some noise
        while (chars_sent < 420) begin
            r = $urandom_range(99);
            if (r < 75) begin
                random_sentence(1'b0);
            end else if (r < 88) begin
                random_sentence(1'b1);
            end else begin
                repeat ($urandom_range(8, 1)) send_char(8'($urandom_range(255)));
            end
        end

        // drain: wait for every expected result, then a few cycles of latency
        chars_if.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("run covered %0d characters with %0d results in %0d payload runs",
                 chars_sent, results_seen, runs_seen);
        $display("including checksum forms, decimal wrap, long terms, restarts and back-pressure");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS aivdm_sentence_parser");
        end else begin
            $display("FAIL aivdm_sentence_parser");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/aivdm_pkg.sv
design/aivdm_stream_if.sv
design/aivdm_parse.sv
design/aivdm_emit.sv
design/aivdm_sentence_parser.sv
tb/aivdm_sentence_checker.sv
tb/aivdm_sentence_parser_test.sv
